// ===== src/wcn_pkg.sv =====
// ----------------------------------------------------------------------------
// wcn_pkg
// Shared types and constants of the windowed coverage normalizer.
// ----------------------------------------------------------------------------
package wcn_pkg;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned DEPTH_W  = 32;
    localparam int unsigned SUM_W    = 64;
    localparam int unsigned WIN_W    = 31;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ITEM_W   = 1 + POS_W + DEPTH_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_DEPTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE   = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 31'd10000;
    localparam logic [Q_W-1:0]   AVG_DEPTH_RST   = 32'd65536;
    localparam logic [Q_W-1:0]   MAX_SCALE_RST   = 32'd65536;

    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_END   = 1'b1;

    typedef struct packed {
        logic [WIN_W-1:0] window_size;
        logic [Q_W-1:0]   avg_depth;
        logic [Q_W-1:0]   max_scale;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [POS_W-1:0]   position;
        logic [DEPTH_W-1:0] delta;
    } item_t;

    typedef struct packed {
        logic [Q_W-1:0]   factor;
        logic [POS_W-1:0] window_index;
        logic             seq_last;
        logic             run_last;
        logic             status;
    } res_t;

endpackage

// ===== src/wcn_queue.sv =====
// ----------------------------------------------------------------------------
// wcn_queue
// Two-entry queue between the input side and the sweep engine.
// ----------------------------------------------------------------------------
module wcn_queue #(
    parameter int unsigned WIDTH = 65
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== src/wcn_div.sv =====
// ----------------------------------------------------------------------------
// wcn_div
// Restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcn_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wcn_pkg::SUM_W-1:0] num,
    input  logic [wcn_pkg::SUM_W-1:0] den,
    output logic                      done,
    output logic [wcn_pkg::SUM_W-1:0] quot
);

    localparam int unsigned CNT_W = $clog2(wcn_pkg::SUM_W);

    logic [wcn_pkg::SUM_W-1:0] rem_reg;
    logic [wcn_pkg::SUM_W-1:0] quo_reg;
    logic [wcn_pkg::SUM_W-1:0] den_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [wcn_pkg::SUM_W-1:0] trial;
    logic                      fits;

    // divisor stays below 2^63, so the shifted remainder fits in 64 bits
    assign trial = {rem_reg[wcn_pkg::SUM_W-2:0], quo_reg[wcn_pkg::SUM_W-1]};
    assign fits  = (trial >= den_reg);
    assign done  = done_reg;
    assign quot  = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - den_reg) : trial;
            quo_reg <= {quo_reg[wcn_pkg::SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(wcn_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/wcn_engine.sv =====
// ----------------------------------------------------------------------------
// wcn_engine
// Sweep engine: checks each item, advances window by window and emits factors or rejections.
// ----------------------------------------------------------------------------
module wcn_engine #(
    parameter int unsigned MAX_WINDOWS_PER_ITEM = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wcn_pkg::cfg_t        cfg,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  wcn_pkg::item_t       item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output wcn_pkg::res_t        res
);

    localparam int unsigned M_W   = $clog2(MAX_WINDOWS_PER_ITEM + 1);
    localparam int unsigned LIM_W = wcn_pkg::WIN_W + M_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_REJ   = 9'b000000100,
        ST_STEP  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_NUM   = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    wcn_pkg::item_t              item_reg;
    logic [wcn_pkg::POS_W-1:0]   sweep_reg;
    logic [wcn_pkg::DEPTH_W-1:0] depth_reg;
    logic [wcn_pkg::POS_W-1:0]   fill_reg;
    logic [wcn_pkg::SUM_W-1:0]   sum_reg;
    logic [wcn_pkg::POS_W-1:0]   count_reg;
    logic [wcn_pkg::POS_W-1:0]   bases_reg;
    logic                        close_reg;
    logic                        last_reg;
    logic                        seq_reg;
    logic [wcn_pkg::SUM_W-1:0]   prod_reg;
    logic [wcn_pkg::Q_W-1:0]     factor_reg;

    logic [wcn_pkg::POS_W-1:0]   win;
    logic [wcn_pkg::POS_W-1:0]   rem;
    logic [wcn_pkg::POS_W-1:0]   gap;
    logic [wcn_pkg::POS_W-1:0]   after;
    logic                        covers;
    logic [LIM_W-1:0]            lim_hi;
    logic [LIM_W-1:0]            lim_lo;
    logic                        reject;
    logic [wcn_pkg::SUM_W-1:0]   num;
    logic [wcn_pkg::SUM_W-1:0]   quot;
    logic                        div_start;
    logic                        div_done;
    logic                        sum_pos;

    assign win    = (cfg.window_size == '0) ? wcn_pkg::POS_W'(1)
                                            : wcn_pkg::POS_W'(cfg.window_size);
    assign rem    = (fill_reg >= win) ? '0 : (win - fill_reg);
    assign gap    = (item_reg.position > sweep_reg) ? (item_reg.position - sweep_reg) : '0;
    assign covers = (gap >= rem) && (gap != '0);
    assign after  = gap - rem;
    assign lim_hi = LIM_W'(win) * LIM_W'(MAX_WINDOWS_PER_ITEM);
    assign lim_lo = LIM_W'(win) * LIM_W'(MAX_WINDOWS_PER_ITEM - 1);
    // the final partial window counts against the limit on an end item
    assign reject = covers && ((LIM_W'(after) >= lim_hi) ||
                    (item_reg.mode == wcn_pkg::MODE_END && LIM_W'(after) > lim_lo));
    assign sum_pos   = (sum_reg != '0) && !sum_reg[wcn_pkg::SUM_W-1];
    assign num       = wcn_pkg::SUM_W'(cfg.avg_depth) * wcn_pkg::SUM_W'(fill_reg);
    assign div_start = (state_reg == ST_NUM) && sum_pos;
    assign item_pop  = (state_reg == ST_IDLE) && item_valid;

    wcn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        case (state_reg)
            ST_REJ: begin
                res_valid        = 1'b1;
                res.window_index = count_reg;
                res.run_last     = 1'b1;
                res.status       = 1'b1;
            end
            ST_OUT: begin
                res_valid        = 1'b1;
                res.factor       = factor_reg;
                res.window_index = count_reg;
                res.seq_last     = seq_reg;
                res.run_last     = last_reg;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (item_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = reject ? ST_REJ : ST_STEP;
            ST_REJ:   if (res_ready) state_next = ST_IDLE;
            ST_STEP: begin
                if (gap != '0 || (item_reg.mode == wcn_pkg::MODE_END && fill_reg != '0)) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = close_reg ? ST_NUM : ST_STEP;
            ST_NUM:   state_next = sum_pos ? ST_DIV : ST_OUT;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (res_ready) state_next = ST_STEP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) item_reg <= item;
            end
            ST_STEP: begin
                if (gap != '0) begin
                    bases_reg <= covers ? rem : gap;
                    close_reg <= covers;
                    last_reg  <= (after < win) && !(item_reg.mode == wcn_pkg::MODE_END
                                                    && after != '0);
                    seq_reg   <= (item_reg.mode == wcn_pkg::MODE_END) && (after < win)
                                 && (after == '0);
                end else begin
                    // closing partial window of the sequence
                    bases_reg <= '0;
                    close_reg <= 1'b1;
                    last_reg  <= 1'b1;
                    seq_reg   <= 1'b1;
                end
            end
            ST_MUL: begin
                prod_reg <= $signed({{wcn_pkg::DEPTH_W{depth_reg[wcn_pkg::DEPTH_W-1]}},
                                     depth_reg})
                            * $signed({{wcn_pkg::POS_W{1'b0}}, bases_reg});
            end
            ST_NUM: begin
                if (!sum_pos) factor_reg <= cfg.max_scale;
            end
            ST_DIV: begin
                if (div_done) begin
                    factor_reg <= (quot < wcn_pkg::SUM_W'(cfg.max_scale))
                                  ? quot[wcn_pkg::Q_W-1:0] : cfg.max_scale;
                end
            end
            default: begin
                factor_reg <= factor_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sweep_reg <= '0;
            depth_reg <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_STEP: begin
                    if (gap == '0) begin
                        if (item_reg.mode == wcn_pkg::MODE_EVENT) begin
                            depth_reg <= depth_reg + item_reg.delta;
                        end else if (fill_reg == '0) begin
                            sweep_reg <= '0;
                            depth_reg <= '0;
                            sum_reg   <= '0;
                            count_reg <= '0;
                        end
                    end
                end
                ST_ACC: begin
                    sum_reg   <= sum_reg + prod_reg;
                    fill_reg  <= fill_reg + bases_reg;
                    sweep_reg <= sweep_reg + bases_reg;
                end
                ST_OUT: begin
                    if (res_ready) begin
                        count_reg <= count_reg + wcn_pkg::POS_W'(1);
                        fill_reg  <= '0;
                        sum_reg   <= '0;
                    end
                end
                default: begin
                    sweep_reg <= sweep_reg;
                end
            endcase
        end
    end

endmodule

// ===== src/windowed_coverage_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_coverage_normalizer_unit
// Per-window coverage normalization factors from sorted depth change events.
// ----------------------------------------------------------------------------
// An event that closes no window bypasses the divider; every window that
// closes with a positive sum runs the 64-step bit-serial divider that forms
// avg_depth * length / sum. A two-entry input queue lets the sender move
// ahead while the engine works, and the result register lets the engine
// continue while a result waits. Items whose gap would close more than
// MAX_WINDOWS_PER_ITEM windows give one result with status set and leave
// the state unchanged. Configuration writes are always taken (cfg_ready high).
module windowed_coverage_normalizer_unit #(
    parameter int unsigned MAX_WINDOWS_PER_ITEM = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // position [31:0], delta [63:32]
    input  logic        s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // factor [31:0], window_index [63:32]
    output logic [1:0]  m_tuser,   // seq_last [0], status [1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wcn_pkg::cfg_t  cfg_reg;
    wcn_pkg::item_t in_item;
    wcn_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;
    wcn_pkg::res_t  res;
    logic           res_valid;
    logic           res_ready;
    wcn_pkg::res_t  out_reg;
    logic           out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_size <= wcn_pkg::WINDOW_SIZE_RST;
            cfg_reg.avg_depth   <= wcn_pkg::AVG_DEPTH_RST;
            cfg_reg.max_scale   <= wcn_pkg::MAX_SCALE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                wcn_pkg::REG_WINDOW_SIZE: cfg_reg.window_size <= cfg_data[30:0];
                wcn_pkg::REG_AVG_DEPTH:   cfg_reg.avg_depth   <= cfg_data;
                wcn_pkg::REG_MAX_SCALE:   cfg_reg.max_scale   <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_item.mode     = s_tuser;
    assign in_item.position = s_tdata[31:0];
    assign in_item.delta    = s_tdata[63:32];

    wcn_queue #(
        .WIDTH (wcn_pkg::ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_item)
    );

    wcn_engine #(
        .MAX_WINDOWS_PER_ITEM (MAX_WINDOWS_PER_ITEM)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // load the result register when empty or drained this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.window_index, out_reg.factor};
    assign m_tuser  = {out_reg.status, out_reg.seq_last};
    assign m_tlast  = out_reg.run_last;

endmodule
